// ===== design/tlq_pkg.sv =====
// tlq_pkg: shared sizes, request and status codes and state type of the task
// linked queue. Used by task_linked_queue; depends on nothing.
package tlq_pkg;

  localparam int NUM_TASKS = 64;
  localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W     = $clog2(NUM_TASKS + 1);

  localparam int MODE_W   = 3;
  localparam int TASK_W   = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_POP    = 3'd3,
    MODE_PEEK   = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_EMPTY      = 2'd1,
    STAT_NOT_QUEUED = 2'd2,
    STAT_DUPLICATE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_UNLINK,
    ST_RESP
  } state_e;

endpackage

// ===== design/tlq_ram.sv =====
// tlq_ram: generic single-port synchronous RAM with registered read data.
// No dependencies.
module tlq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/task_linked_queue.sv =====
// task_linked_queue: ordered queue of task ids kept as a linked table of next
// links in one single-port RAM. Depends on tlq_pkg and tlq_ram.
//
// Each request takes one transaction in and gives one transaction out. The
// successor links live in a single-port RAM with registered read data, so
// every link traversal is a separate RAM read. Insert, peek, duplicate and
// rejected requests go straight from acceptance to the response state; pop
// and removal of the head pass through the unlink state; append walks the
// links to the tail when the head has a successor; removal from inside the
// queue walks the links from the head to the removed task and then unlinks
// it. A new request is accepted in the cycle after the result is loaded into
// the output register, even while that result is still waiting to be taken.
module task_linked_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tlq_pkg::MODE_W-1:0]    mode_i,
  input  logic [tlq_pkg::TASK_W-1:0]    task_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tlq_pkg::STATUS_W-1:0]  status_o,
  output logic [tlq_pkg::TASK_W-1:0]    result_task_o,
  output logic                          result_valid_o,
  output logic [tlq_pkg::COUNT_W-1:0]   queued_count_o,
  output logic                          is_empty_o
);

  tlq_pkg::state_e state_q, state_d;

  logic [tlq_pkg::MODE_W-1:0]    mode_q, mode_d;
  logic [tlq_pkg::TASK_W-1:0]    task_q, task_d;
  tlq_pkg::idx_t                 cur_q, cur_d;
  logic                          is_head_q, is_head_d;

  tlq_pkg::idx_t                 head_q, head_d;
  logic                          head_valid_q, head_valid_d;
  logic [tlq_pkg::CNT_W-1:0]     count_q, count_d;
  logic [tlq_pkg::NUM_TASKS-1:0] lv_q, lv_d;
  logic [tlq_pkg::NUM_TASKS-1:0] mark_q, mark_d;

  tlq_pkg::status_e              res_status_q, res_status_d;
  logic [tlq_pkg::TASK_W-1:0]    res_task_q, res_task_d;
  logic                          res_valid_q, res_valid_d;

  logic                          out_valid_q, out_valid_d;
  tlq_pkg::status_e              out_status_q, out_status_d;
  logic [tlq_pkg::TASK_W-1:0]    out_task_q, out_task_d;
  logic                          out_rvalid_q, out_rvalid_d;
  logic [tlq_pkg::COUNT_W-1:0]   out_count_q, out_count_d;
  logic                          out_empty_q, out_empty_d;

  logic                          ram_we;
  tlq_pkg::idx_t                 ram_addr;
  tlq_pkg::idx_t                 ram_wdata;
  tlq_pkg::idx_t                 ram_rdata;

  tlq_pkg::idx_t                 in_idx;
  tlq_pkg::idx_t                 task_idx;
  logic                          in_table;
  logic                          in_marked;
  logic                          head_linked;
  logic                          nx_linked;
  logic                          nx_hit;
  logic                          task_linked;
  logic                          acc;
  logic                          out_free;
  logic                          is_append;

  tlq_ram #(
    .WIDTH (tlq_pkg::IDX_W),
    .DEPTH (tlq_pkg::NUM_TASKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == tlq_pkg::ST_IDLE);
  assign acc         = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign in_idx      = tlq_pkg::IDX_W'(task_id_i);
  assign task_idx    = tlq_pkg::IDX_W'(task_q);
  assign in_table    = (32'(task_id_i) < tlq_pkg::NUM_TASKS);
  assign in_marked   = in_table && mark_q[in_idx];
  assign head_linked = lv_q[head_q];
  // in the walk, ram_rdata is the successor of cur_q
  assign nx_linked   = lv_q[ram_rdata];
  assign nx_hit      = (ram_rdata == task_idx);
  assign task_linked = lv_q[task_idx];
  assign is_append   = (mode_q == tlq_pkg::MODE_APPEND);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tlq_pkg::ST_IDLE: begin
        if (acc) begin
          case (mode_i)
            tlq_pkg::MODE_APPEND: begin
              if (!in_table || in_marked || !head_valid_q || !head_linked) begin
                state_d = tlq_pkg::ST_RESP;
              end else begin
                state_d = tlq_pkg::ST_WALK;
              end
            end
            tlq_pkg::MODE_REMOVE: begin
              if (!in_marked) begin
                state_d = tlq_pkg::ST_RESP;
              end else if (head_q == in_idx) begin
                state_d = tlq_pkg::ST_UNLINK;
              end else if (head_linked) begin
                state_d = tlq_pkg::ST_WALK;
              end else begin
                state_d = tlq_pkg::ST_RESP;
              end
            end
            tlq_pkg::MODE_POP: begin
              state_d = head_valid_q ? tlq_pkg::ST_UNLINK : tlq_pkg::ST_RESP;
            end
            default: begin
              state_d = tlq_pkg::ST_RESP;
            end
          endcase
        end
      end
      tlq_pkg::ST_WALK: begin
        if (is_append) begin
          state_d = nx_linked ? tlq_pkg::ST_WALK : tlq_pkg::ST_RESP;
        end else if (nx_hit) begin
          state_d = tlq_pkg::ST_UNLINK;
        end else if (nx_linked) begin
          state_d = tlq_pkg::ST_WALK;
        end else begin
          state_d = tlq_pkg::ST_RESP;
        end
      end
      tlq_pkg::ST_UNLINK: begin
        state_d = tlq_pkg::ST_RESP;
      end
      tlq_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = tlq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tlq_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    mode_d       = mode_q;
    task_d       = task_q;
    cur_d        = cur_q;
    is_head_d    = is_head_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    count_d      = count_q;
    lv_d         = lv_q;
    mark_d       = mark_q;
    res_status_d = res_status_q;
    res_task_d   = res_task_q;
    res_valid_d  = res_valid_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_task_d   = out_task_q;
    out_rvalid_d = out_rvalid_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    ram_we       = 1'b0;
    ram_addr     = head_q;
    ram_wdata    = head_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      tlq_pkg::ST_IDLE: begin
        if (acc) begin
          mode_d       = mode_i;
          task_d       = task_id_i;
          res_status_d = tlq_pkg::STAT_OK;
          res_task_d   = '0;
          res_valid_d  = 1'b0;
          case (mode_i)
            tlq_pkg::MODE_APPEND, tlq_pkg::MODE_INSERT: begin
              if (!in_table) begin
                res_status_d = tlq_pkg::STAT_NOT_QUEUED;
              end else if (in_marked) begin
                res_status_d = tlq_pkg::STAT_DUPLICATE;
              end else begin
                mark_d[in_idx] = 1'b1;
                count_d        = count_q + tlq_pkg::CNT_W'(1);
                res_task_d     = task_id_i;
                res_valid_d    = 1'b1;
                if (mode_i == tlq_pkg::MODE_INSERT || !head_valid_q) begin
                  ram_we         = 1'b1;
                  ram_addr       = in_idx;
                  ram_wdata      = head_q;
                  lv_d[in_idx]   = head_valid_q;
                  head_d         = in_idx;
                  head_valid_d   = 1'b1;
                end else begin
                  lv_d[in_idx] = 1'b0;
                  if (head_linked) begin
                    ram_addr = head_q;
                    cur_d    = head_q;
                  end else begin
                    // head is the tail
                    ram_we       = 1'b1;
                    ram_addr     = head_q;
                    ram_wdata    = in_idx;
                    lv_d[head_q] = 1'b1;
                  end
                end
              end
            end
            tlq_pkg::MODE_REMOVE: begin
              if (!in_marked) begin
                res_status_d = tlq_pkg::STAT_NOT_QUEUED;
              end else if (head_q == in_idx) begin
                ram_addr  = in_idx;
                is_head_d = 1'b1;
              end else if (head_linked) begin
                ram_addr  = head_q;
                cur_d     = head_q;
                is_head_d = 1'b0;
              end else begin
                res_status_d = tlq_pkg::STAT_NOT_QUEUED;
              end
            end
            tlq_pkg::MODE_POP: begin
              if (!head_valid_q) begin
                res_status_d = tlq_pkg::STAT_EMPTY;
              end else begin
                ram_addr  = head_q;
                is_head_d = 1'b1;
                task_d    = tlq_pkg::TASK_W'(head_q);
              end
            end
            tlq_pkg::MODE_PEEK: begin
              if (!head_valid_q) begin
                res_status_d = tlq_pkg::STAT_EMPTY;
              end else begin
                res_task_d  = tlq_pkg::TASK_W'(head_q);
                res_valid_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tlq_pkg::ST_WALK: begin
        if (is_append) begin
          if (nx_linked) begin
            ram_addr = ram_rdata;
            cur_d    = ram_rdata;
          end else begin
            ram_we          = 1'b1;
            ram_addr        = ram_rdata;
            ram_wdata       = task_idx;
            lv_d[ram_rdata] = 1'b1;
          end
        end else if (nx_hit) begin
          // cur_q is the predecessor, fetch the successor of the removed task
          ram_addr  = task_idx;
          is_head_d = 1'b0;
        end else if (nx_linked) begin
          ram_addr = ram_rdata;
          cur_d    = ram_rdata;
        end else begin
          res_status_d = tlq_pkg::STAT_NOT_QUEUED;
          res_task_d   = '0;
          res_valid_d  = 1'b0;
        end
      end
      tlq_pkg::ST_UNLINK: begin
        if (is_head_q) begin
          head_valid_d = task_linked;
          head_d       = task_linked ? ram_rdata : '0;
        end else begin
          ram_we      = 1'b1;
          ram_addr    = cur_q;
          ram_wdata   = ram_rdata;
          lv_d[cur_q] = task_linked;
        end
        lv_d[task_idx]   = 1'b0;
        mark_d[task_idx] = 1'b0;
        if (count_q != '0) begin
          count_d = count_q - tlq_pkg::CNT_W'(1);
        end
        res_status_d = tlq_pkg::STAT_OK;
        res_task_d   = task_q;
        res_valid_d  = 1'b1;
      end
      tlq_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_task_d   = res_task_q;
          out_rvalid_d = res_valid_q;
          out_count_d  = tlq_pkg::COUNT_W'(count_q);
          out_empty_d  = !head_valid_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tlq_pkg::ST_IDLE;
      head_q       <= '0;
      head_valid_q <= 1'b0;
      count_q      <= '0;
      lv_q         <= '0;
      mark_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      count_q      <= count_d;
      lv_q         <= lv_d;
      mark_q       <= mark_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    task_q       <= task_d;
    cur_q        <= cur_d;
    is_head_q    <= is_head_d;
    res_status_q <= res_status_d;
    res_task_q   <= res_task_d;
    res_valid_q  <= res_valid_d;
    out_status_q <= out_status_d;
    out_task_q   <= out_task_d;
    out_rvalid_q <= out_rvalid_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_task_o  = out_task_q;
  assign result_valid_o = out_rvalid_q;
  assign queued_count_o = out_count_q;
  assign is_empty_o     = out_empty_q;

  // head and count must agree on emptiness
  a_head_matches_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_q == (count_q != '0))
    else $error("head valid flag disagrees with task count");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= tlq_pkg::NUM_TASKS)
    else $error("task count exceeds table size");

  a_head_marked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_q |-> mark_q[head_q])
    else $error("head task is not marked as queued");

  // the walk only follows links that were written
  a_walk_linked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tlq_pkg::ST_WALK) |-> lv_q[cur_q])
    else $error("walk reads an unlinked entry");

  a_out_from_resp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == tlq_pkg::ST_RESP))
    else $error("result transaction raised outside the response state");

endmodule
